/* src/sdws_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and pixel functions for the scan doubler.
// No dependencies.
package sdws_pkg;

  localparam int LINE_PIXELS = 720;
  localparam int STORE_LINES = 288;
  localparam int STORE_DEPTH = LINE_PIXELS * STORE_LINES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [8:0]  LINE_COUNT_MAX = 9'd511;
  localparam logic [15:0] DIM_QUARTER_MASK = 16'hE79C;
  localparam logic [15:0] DIM_HALF_MASK    = 16'hF7DE;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_VSYNC = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_DIM_PROG  = 2'd0,
    CFG_DIM_ILACE = 2'd1,
    CFG_PAL_THR   = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    DIM_BLACK   = 3'd0,
    DIM_QUARTER = 3'd1,
    DIM_HALF    = 3'd2,
    DIM_3QUART  = 3'd3
  } dim_level_t;

  // request from the pipeline to the field store
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
  } store_req_t;

  function automatic logic [15:0] expand_444(input logic [11:0] raw);
    logic [3:0] r;
    logic [3:0] g;
    logic [3:0] b;
    r = raw[3:0];
    g = raw[7:4];
    b = raw[11:8];
    return {r, r[3], g, g[3:2], b, b[3]};
  endfunction

  function automatic logic [15:0] dim_pixel(input logic [15:0] p, input logic [2:0] level);
    logic [15:0] res;
    case (level)
      DIM_3QUART:  res = p - ((p & DIM_QUARTER_MASK) >> 2);
      DIM_HALF:    res = (p & DIM_HALF_MASK) >> 1;
      DIM_QUARTER: res = (p & DIM_QUARTER_MASK) >> 2;
      DIM_BLACK:   res = 16'd0;
      default:     res = p;
    endcase
    return res;
  endfunction

endpackage

/* src/sdws_field_store.sv */
`timescale 1ns / 1ps
// Previous-field pixel store: single-port-write, registered-read memory with
// a zeroing sweep after reset and write-to-read forwarding. Uses sdws_pkg.
module sdws_field_store
  import sdws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  store_req_t  req,
  output logic        busy,
  output logic [15:0] rd_data
);

  logic [15:0]       mem [STORE_DEPTH];
  logic [15:0]       mem_q;
  logic [ADDR_W-1:0] clr_addr;
  logic              fwd_hit;
  logic [15:0]       fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read sees the new word (forwarded) when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mem_q    <= mem[req.rd_addr];
      fwd_hit  <= req.wr_en && (req.wr_addr == req.rd_addr);
      fwd_data <= req.wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

/* src/scan_doubler_weave_scanlines.sv */
`timescale 1ns / 1ps
// Scan doubler top: line/vsync bookkeeping, weave and scanline dimming.
// Uses sdws_pkg and sdws_field_store.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  input   | in        | in_valid/in_stall  | cmd, pixel_raw, column, active_line
//  output  | out       | out_valid/out_stall| upper_pixel, lower_pixel, flags
//  config  | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One event per clock sustained while in_stall is low; each accepted event passes
// the store read stage, then the output register. The field store read is
// registered; a read of an entry written in the same cycle gets the new word.
// After reset the store is zeroed, during which in_stall is high; config writes
// are taken at any time. An output stall holds one result and one more event
// in flight before in_stall rises.
module scan_doubler_weave_scanlines
  import sdws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [11:0] pixel_raw,
  input  logic [9:0]  column,
  input  logic [8:0]  active_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] upper_pixel,
  output logic [15:0] lower_pixel,
  output logic        interlaced_now,
  output logic        pal_now,
  output logic        odd_field_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  logic [2:0] dim_prog;
  logic [2:0] dim_ilace;
  logic [8:0] pal_thr;

  logic [8:0] line_count, line_count_next;
  logic [8:0] prev_lines, prev_lines_next;
  logic       ilace, ilace_next;
  logic       pal, pal_next;
  logic       odd, odd_next;

  logic              accept;
  logic              is_pix;
  logic              in_range;
  logic [ADDR_W-1:0] addr;

  logic              s1_valid;
  logic              s1_adv;
  logic              s1_is_pix;
  logic [15:0]       s1_cur;
  logic              s1_inside;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_ilace;
  logic              s1_pal;
  logic              s1_odd;

  logic [15:0] stored;
  logic [15:0] upper_calc;
  logic [15:0] lower_calc;
  logic        cur_first;

  store_req_t  store_req;
  logic        store_busy;
  logic [15:0] store_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_prog  <= 3'd4;
      dim_ilace <= 3'd4;
      pal_thr   <= 9'd300;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DIM_PROG:  dim_prog  <= cfg_data[2:0];
        CFG_DIM_ILACE: dim_ilace <= cfg_data[2:0];
        CFG_PAL_THR:   pal_thr   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = store_busy || (s1_valid && !s1_adv);
  assign accept   = in_valid && !in_stall;
  assign is_pix   = (cmd == CMD_PIXEL);
  assign in_range = (32'(column) < LINE_PIXELS) && (32'(active_line) < STORE_LINES);
  assign addr     = ADDR_W'(active_line) * ADDR_W'(LINE_PIXELS) + ADDR_W'(column);

  always_comb begin
    line_count_next = line_count;
    prev_lines_next = prev_lines;
    ilace_next      = ilace;
    pal_next        = pal;
    odd_next        = odd;
    case (cmd)
      CMD_LINE: begin
        if (line_count != LINE_COUNT_MAX) begin
          line_count_next = line_count + 1'b1;
        end
      end
      CMD_VSYNC: begin
        ilace_next      = (prev_lines != line_count);
        pal_next        = (prev_lines > pal_thr);
        odd_next        = line_count[0];
        prev_lines_next = line_count;
        line_count_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      prev_lines <= '0;
      ilace      <= 1'b0;
      pal        <= 1'b1;
      odd        <= 1'b1;
    end else if (accept) begin
      line_count <= line_count_next;
      prev_lines <= prev_lines_next;
      ilace      <= ilace_next;
      pal        <= pal_next;
      odd        <= odd_next;
    end
  end

  // store read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_is_pix <= is_pix;
      s1_cur    <= expand_444(pixel_raw);
      s1_inside <= in_range;
      s1_addr   <= addr;
      s1_ilace  <= ilace_next;
      s1_pal    <= pal_next;
      s1_odd    <= odd_next;
    end
  end

  always_comb begin
    store_req.rd_en   = accept && is_pix && ilace && in_range;
    store_req.rd_addr = addr;
    store_req.wr_en   = s1_valid && s1_adv && s1_is_pix && s1_ilace && s1_inside;
    store_req.wr_addr = s1_addr;
    store_req.wr_data = s1_cur;
  end

  sdws_field_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .busy    (store_busy),
    .rd_data (store_rd)
  );

  assign stored    = s1_inside ? store_rd : 16'd0;
  assign cur_first = s1_pal ? s1_odd : !s1_odd;

  always_comb begin
    upper_calc = 16'd0;
    lower_calc = 16'd0;
    if (s1_is_pix) begin
      if (!s1_ilace) begin
        upper_calc = s1_cur;
        lower_calc = dim_pixel(s1_cur, dim_prog);
      end else if (cur_first) begin
        upper_calc = dim_pixel(s1_cur, dim_ilace);
        lower_calc = stored;
      end else begin
        upper_calc = dim_pixel(stored, dim_ilace);
        lower_calc = s1_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      upper_pixel    <= upper_calc;
      lower_pixel    <= lower_calc;
      interlaced_now <= s1_ilace;
      pal_now        <= s1_pal;
      odd_field_now  <= s1_odd;
    end
  end

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    store_busy |-> in_stall)
    else $error("event accepted during store clear");

  a_no_write_clearing: assert property (@(posedge clk) disable iff (rst)
    store_req.wr_en |-> !store_busy)
    else $error("store write during clear");

  a_vsync_same_count: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_VSYNC && prev_lines == line_count) |=> !ilace)
    else $error("interlace set with equal field counts");

  a_line_saturate: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_LINE && line_count == LINE_COUNT_MAX)
      |=> line_count == LINE_COUNT_MAX)
    else $error("line count wrapped");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for scan_doubler_weave_scanlines: directed and random event
// streams, a cycle-free predictor of the doubled/woven pixels and mode flags.
// Depends on sdws_pkg and the scan_doubler_weave_scanlines RTL.
module tb
  import sdws_pkg::*;
();

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  // the clearing pass after reset stalls the input; the limit leaves ample margin
  localparam int IDLE_LIMIT = 700_000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [15:0] upper;
    logic [15:0] lower;
    logic        ilace;
    logic        pal;
    logic        odd;
  } scan_pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = 2'd0;
  logic [11:0] pixel_raw = 12'd0;
  logic [9:0]  column = 10'd0;
  logic [8:0]  active_line = 9'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] upper_pixel;
  logic [15:0] lower_pixel;
  logic        interlaced_now;
  logic        pal_now;
  logic        odd_field_now;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [8:0]  cfg_data = 9'd0;

  scan_doubler_weave_scanlines dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [2:0]  dim_prog_q = 3'd4;
  logic [2:0]  dim_ilace_q = 3'd4;
  logic [8:0]  pal_thr_q = 9'd300;
  logic [8:0]  lines_seen = 9'd0;
  logic [8:0]  prev_lines = 9'd0;
  logic        ilace_q = 1'b0;
  logic        pal_q = 1'b1;
  logic        odd_q = 1'b1;
  logic [15:0] field_image [int];

  scan_pair_t scan_pairs_due [$];

  int  mismatches = 0;
  int  events_sent = 0;
  int  results_checked = 0;
  int  reg_writes = 0;
  int  idle_cycles = 0;
  int  hold_off_seq = 0;
  bit  gap_quiet = 1'b0;
  bit  stall_quiet = 1'b0;

  function automatic logic [15:0] to_rgb565(input logic [11:0] raw);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = {raw[3:0], raw[3]};
    g6 = {raw[7:4], raw[7:6]};
    b5 = {raw[11:8], raw[11]};
    return {r5, g6, b5};
  endfunction

  function automatic logic [15:0] scanline_dim(input logic [15:0] p, input logic [2:0] lvl);
    logic [15:0] quarter;
    logic [15:0] half;
    quarter = {2'b00, p[15:2]} & 16'h39E7;
    half    = {1'b0, p[15:1]} & 16'h7BEF;
    case (lvl)
      DIM_3QUART:  return p - quarter;
      DIM_HALF:    return half;
      DIM_QUARTER: return quarter;
      DIM_BLACK:   return 16'd0;
      default:     return p;
    endcase
  endfunction

  function automatic scan_pair_t predict_scan_pair(input logic [1:0] c, input logic [11:0] raw,
                                                   input logic [9:0] col, input logic [8:0] ln);
    scan_pair_t res;
    logic [15:0] cur;
    logic [15:0] stored;
    bit          in_store;
    int          addr;
    res = '0;
    case (c)
      CMD_LINE: begin
        if (lines_seen < LINE_COUNT_MAX) lines_seen++;
      end
      CMD_VSYNC: begin
        ilace_q = (prev_lines != lines_seen);
        pal_q = (prev_lines > pal_thr_q);
        odd_q = lines_seen[0];
        prev_lines = lines_seen;
        lines_seen = 9'd0;
      end
      CMD_PIXEL: begin
        cur = to_rgb565(raw);
        if (!ilace_q) begin
          res.upper = cur;
          res.lower = scanline_dim(cur, dim_prog_q);
        end else begin
          in_store = (int'(col) < LINE_PIXELS) && (int'(ln) < STORE_LINES);
          addr = int'(ln) * LINE_PIXELS + int'(col);
          stored = (in_store && field_image.exists(addr)) ? field_image[addr] : 16'd0;
          // current pixel goes on top for PAL odd and NTSC even fields
          if (pal_q ? odd_q : !odd_q) begin
            res.upper = scanline_dim(cur, dim_ilace_q);
            res.lower = stored;
          end else begin
            res.upper = scanline_dim(stored, dim_ilace_q);
            res.lower = cur;
          end
          if (in_store) field_image[addr] = cur;
        end
      end
      default: ;
    endcase
    res.ilace = ilace_q;
    res.pal = pal_q;
    res.odd = odd_q;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [9:0] pick_column();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 10'($urandom_range(0, 7));
    if (r < 80) return 10'(LINE_PIXELS - 1);
    if (r < 90) return 10'($urandom_range(LINE_PIXELS - 8, LINE_PIXELS - 2));
    return 10'($urandom_range(LINE_PIXELS, 1023));
  endfunction

  function automatic logic [8:0] pick_line(input int l);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 9'(l);
    if (r < 90) return 9'(STORE_LINES - 1);
    return 9'($urandom_range(STORE_LINES, 511));
  endfunction

  task automatic send_event(input logic [1:0] c, input logic [11:0] raw,
                            input logic [9:0] col, input logic [8:0] ln);
    int gap;
    gap = gap_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    pixel_raw <= raw;
    column <= col;
    active_line <= ln;
    do @(posedge clk); while (in_stall !== 1'b0);
    scan_pairs_due.push_back(predict_scan_pair(c, raw, col, ln));
    events_sent++;
  endtask

  task automatic send_noise();
    send_event(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
               10'($urandom_range(0, 1023)), 9'($urandom_range(0, 511)));
  endtask

  // wait until every request has produced its result
  task automatic drain();
    in_valid <= 1'b0;
    while (scan_pairs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_DIM_PROG:  dim_prog_q = data[2:0];
      CFG_DIM_ILACE: dim_ilace_q = data[2:0];
      CFG_PAL_THR:   pal_thr_q = data;
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one field: pixels on each line, a line tick after each line but the last, then vsync
  task automatic run_field(input int n_lines, input int px_per_line, input bit pinned);
    for (int l = 0; l <= n_lines; l++) begin
      for (int p = 0; p < px_per_line; p++) begin
        if (pinned)
          send_event(CMD_PIXEL, 12'($urandom_range(0, 4095)), 10'(p), 9'(l));
        else
          send_event(CMD_PIXEL, 12'($urandom_range(0, 4095)), pick_column(), pick_line(l));
      end
      if (l < n_lines) send_event(CMD_LINE, 12'd0, 10'd0, 9'd0);
    end
    send_event(CMD_VSYNC, 12'd0, 10'd0, 9'd0);
  endtask

  task automatic test_reset_defaults();
    send_event(CMD_PIXEL, 12'hFFF, 10'd0, 9'd0);
    send_event(CMD_PIXEL, 12'h000, 10'd1023, 9'd511);
    send_event(CMD_UNUSED, 12'hFFF, 10'd1023, 9'd511);
    send_event(CMD_LINE, 12'd0, 10'd0, 9'd0);
    send_event(CMD_VSYNC, 12'd0, 10'd0, 9'd0);
    send_event(CMD_VSYNC, 12'd0, 10'd0, 9'd0);
    // equal counts bring it back to progressive
    send_event(CMD_VSYNC, 12'd0, 10'd0, 9'd0);
  endtask

  task automatic test_progressive_levels();
    for (int lvl = 0; lvl < 8; lvl++) begin
      drain();
      write_reg(CFG_DIM_PROG, 9'(lvl));
      send_event(CMD_PIXEL, 12'hFFF, 10'(lvl), 9'd0);
      send_event(CMD_PIXEL, 12'($urandom_range(0, 4095)), 10'(lvl), 9'd1);
    end
    drain();
    write_reg(CFG_UNUSED, 9'h1FF);
  endtask

  // counts 3,2,1,0,1,1 with threshold 1 walk through all four weave orders
  task automatic test_weave_orders();
    int counts [6] = '{3, 2, 1, 0, 1, 1};
    drain();
    write_reg(CFG_PAL_THR, 9'd1);
    write_reg(CFG_DIM_ILACE, 9'(DIM_HALF));
    foreach (counts[i]) begin
      send_event(CMD_PIXEL, 12'($urandom_range(0, 4095)), 10'(LINE_PIXELS - 1),
                 9'(STORE_LINES - 1));
      send_event(CMD_PIXEL, 12'($urandom_range(0, 4095)), 10'(LINE_PIXELS), 9'd0);
      run_field(counts[i], 1, 1'b1);
    end
  endtask

  task automatic test_line_saturation();
    drain();
    write_reg(CFG_PAL_THR, 9'd511);
    gap_quiet = 1'b1;
    repeat (515) send_event(CMD_LINE, 12'd0, 10'd0, 9'd0);
    send_event(CMD_VSYNC, 12'd0, 10'd0, 9'd0);
    gap_quiet = 1'b0;
    run_field(2, 1, 1'b0);
    drain();
    write_reg(CFG_PAL_THR, 9'd0);
    run_field(2, 1, 1'b0);
    run_field(3, 1, 1'b0);
  endtask

  task automatic test_backpressure();
    drain();
    write_reg(CFG_DIM_ILACE, 9'(DIM_3QUART));
    hold_off_seq++;
    gap_quiet = 1'b1;
    repeat (3) run_field(3, 2, 1'b0);
    gap_quiet = 1'b0;
    drain();
    run_field(2, 2, 1'b0);
    run_field(3, 2, 1'b0);
  endtask

  task automatic test_random_fields();
    int start;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_DIM_PROG, 9'(DIM_BLACK));
          write_reg(CFG_DIM_ILACE, 9'(DIM_BLACK));
          write_reg(CFG_PAL_THR, 9'd0);
        end
        1: begin
          write_reg(CFG_DIM_PROG, 9'd4);
          write_reg(CFG_DIM_ILACE, 9'd4);
          write_reg(CFG_PAL_THR, 9'd511);
        end
        default: begin
          write_reg(CFG_DIM_PROG, 9'($urandom_range(0, 511)));
          write_reg(CFG_DIM_ILACE, 9'($urandom_range(0, 7)));
          write_reg(CFG_PAL_THR, ($urandom_range(0, 1) != 0) ? 9'($urandom_range(0, 10))
                                                             : 9'($urandom_range(0, 511)));
        end
      endcase
      stall_quiet = (ph == 2);
      gap_quiet = (ph == 3);
      start = events_sent;
      while (events_sent - start < 12) begin
        if ($urandom_range(0, 99) < 85)
          run_field($urandom_range(0, 9), $urandom_range(0, 3), 1'b0);
        else
          repeat ($urandom_range(1, 4)) send_noise();
      end
    end
    stall_quiet = 1'b0;
    gap_quiet = 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    scan_pair_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (scan_pairs_due.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = scan_pairs_due.pop_front();
        check_field("upper_pixel", want.upper, upper_pixel);
        check_field("lower_pixel", want.lower, lower_pixel);
        check_field("interlaced_now", 16'(want.ilace), 16'(interlaced_now));
        check_field("pal_now", 16'(want.pal), 16'(pal_now));
        check_field("odd_field_now", 16'(want.odd), 16'(odd_field_now));
        results_checked++;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  int stall_left = 0;
  int free_left = 0;
  int hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    if (hold_off_seq != hold_seen) begin
      hold_seen = hold_off_seq;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      free_left = $urandom_range(0, 12);
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 3);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("scan_doubler_weave_scanlines test failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_progressive_levels();
    test_weave_orders();
    test_line_saturation();
    test_backpressure();
    test_random_fields();
    drain();
    repeat (8) @(posedge clk);
    $display("%0d events, %0d results checked, %0d register writes", events_sent,
             results_checked, reg_writes);
    $display("dim levels 0-7, all weave orders, line saturation, hold-off and noise covered");
    if (mismatches == 0)
      $display("scan_doubler_weave_scanlines test passed");
    else
      $display("scan_doubler_weave_scanlines test failed");
    $finish;
  end

endmodule
